/* rtl/core/trel_pkg.sv */
// ----------------------------------------------------------------------------
// trel_pkg
// Shared constants, codes, types and ring address helpers for the
// triple ring event logger.
// ----------------------------------------------------------------------------
package trel_pkg;

   // ring depths
   localparam int TELE_DEPTH = 16;
   localparam int WARN_DEPTH = 8;
   localparam int ERR_DEPTH  = 8;

   // slot address widths (at least one bit)
   localparam int TELE_AW = (TELE_DEPTH > 1) ? $clog2(TELE_DEPTH) : 1;
   localparam int WARN_AW = (WARN_DEPTH > 1) ? $clog2(WARN_DEPTH) : 1;
   localparam int ERR_AW  = (ERR_DEPTH > 1) ? $clog2(ERR_DEPTH) : 1;

   // fill count widths (must hold the depth itself)
   localparam int TELE_CW = $clog2(TELE_DEPTH + 1);
   localparam int WARN_CW = $clog2(WARN_DEPTH + 1);
   localparam int ERR_CW  = $clog2(ERR_DEPTH + 1);

   // field widths
   localparam int FUNC_W  = 3;
   localparam int CAT_W   = 2;
   localparam int IDX_W   = 4;
   localparam int STAMP_W = 32;
   localparam int CODE_W  = 16;
   localparam int VALUE_W = 32;
   localparam int FILL_W  = 5;
   localparam int ENTRY_W = STAMP_W + CODE_W + VALUE_W;

   // working width for ring address math: covers 2*depth + index
   localparam int SUM_W = 10;

   typedef logic [SUM_W-1:0] trel_sum_type;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_LOG_TELE   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOG_WARN   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOG_ERR    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ_FIRST = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd5;

   // ring categories
   localparam logic [CAT_W-1:0] CAT_TELE = 2'd0;
   localparam logic [CAT_W-1:0] CAT_WARN = 2'd1;
   localparam logic [CAT_W-1:0] CAT_ERR  = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH
   } trel_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic execute;   // ring write, counters, flag, RAM read issue
      logic respond;   // load the response register
   } trel_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // response register can take a new result
   } trel_status_type;

   // slot of the idx-th oldest entry; head < depth and count <= depth
   function automatic trel_sum_type ring_slot(trel_sum_type head, trel_sum_type count,
                                              trel_sum_type idx, trel_sum_type depth);
      trel_sum_type oldest;
      trel_sum_type pos;
      oldest = head + depth - count;
      if (oldest >= depth) begin
         oldest = oldest - depth;
      end
      pos = oldest + idx;
      if (pos >= depth) begin
         pos = pos - depth;
      end
      return pos;
   endfunction

   // head after one push
   function automatic trel_sum_type ring_next_head(trel_sum_type head, trel_sum_type depth);
      trel_sum_type plus;
      plus = head + trel_sum_type'(1);
      return (plus == depth) ? trel_sum_type'(0) : plus;
   endfunction

   // count after one push, saturating at depth
   function automatic trel_sum_type ring_next_count(trel_sum_type count, trel_sum_type depth);
      return (count < depth) ? count + trel_sum_type'(1) : count;
   endfunction

endpackage

/* rtl/core/trel_ram.sv */
// ----------------------------------------------------------------------------
// trel_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module trel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/trel_ctrl.sv */
// ----------------------------------------------------------------------------
// trel_ctrl
// Sequencer for the event logger: accept, execute, respond.
// ----------------------------------------------------------------------------
module trel_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  trel_pkg::trel_status_type status,
   output trel_pkg::trel_cmd_type    cmd
);

   import trel_pkg::*;

   trel_state_type state_ff;
   trel_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_FETCH: begin
            cmd.respond = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/trel_dp.sv */
// ----------------------------------------------------------------------------
// trel_dp
// Datapath: request latch, three ring RAMs with head and count registers,
// sticky error flag, first error record and the response register.
// ----------------------------------------------------------------------------
module trel_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  trel_pkg::trel_cmd_type          cmd,
   output trel_pkg::trel_status_type       status,
   input  logic                            cfg_write,
   input  logic                            cfg_handler_enable,
   input  logic [trel_pkg::FUNC_W-1:0]     req_func,
   input  logic [trel_pkg::CAT_W-1:0]      req_category,
   input  logic [trel_pkg::IDX_W-1:0]      req_entry_index,
   input  logic [trel_pkg::STAMP_W-1:0]    req_stamp,
   input  logic [trel_pkg::CODE_W-1:0]     req_message_code,
   input  logic [trel_pkg::VALUE_W-1:0]    req_event_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [trel_pkg::STAMP_W-1:0]    rsp_out_stamp,
   output logic [trel_pkg::CODE_W-1:0]     rsp_out_code,
   output logic [trel_pkg::VALUE_W-1:0]    rsp_out_value,
   output logic                            rsp_entry_valid,
   output logic [trel_pkg::FILL_W-1:0]     rsp_fill_count,
   output logic                            rsp_error_flag,
   output logic                            rsp_handler_call
);

   import trel_pkg::*;

   localparam trel_sum_type TELE_D = trel_sum_type'(TELE_DEPTH);
   localparam trel_sum_type WARN_D = trel_sum_type'(WARN_DEPTH);
   localparam trel_sum_type ERR_D  = trel_sum_type'(ERR_DEPTH);

   // latched request
   logic [FUNC_W-1:0]  func_ff;
   logic [CAT_W-1:0]   cat_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [ENTRY_W-1:0] entry_ff;

   // ring control state
   logic [TELE_AW-1:0] tele_head_ff, tele_head_in;
   logic [TELE_CW-1:0] tele_count_ff, tele_count_in;
   logic [WARN_AW-1:0] warn_head_ff, warn_head_in;
   logic [WARN_CW-1:0] warn_count_ff, warn_count_in;
   logic [ERR_AW-1:0]  err_head_ff, err_head_in;
   logic [ERR_CW-1:0]  err_count_ff, err_count_in;
   logic               sticky_ff, sticky_in;
   logic [ENTRY_W-1:0] first_rec_ff, first_rec_in;
   logic               call_ff, call_in;
   logic               handler_enable_ff;

   // response register
   logic               rsp_valid_ff;
   logic [ENTRY_W-1:0] rsp_entry_ff, rsp_entry_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [FILL_W-1:0]  rsp_fill_ff, rsp_fill_in;
   logic               rsp_flag_ff;
   logic               rsp_call_ff;

   // RAM ports
   logic               tele_we, warn_we, err_we;
   logic [TELE_AW-1:0] tele_rd_addr;
   logic [WARN_AW-1:0] warn_rd_addr;
   logic [ERR_AW-1:0]  err_rd_addr;
   logic [ENTRY_W-1:0] tele_rd_data, warn_rd_data, err_rd_data;

   // widened copies for address math
   trel_sum_type tele_head_s, tele_count_s, warn_head_s, warn_count_s;
   trel_sum_type err_head_s, err_count_s, idx_s;
   trel_sum_type warn_count_next;
   logic         error_event;

   assign tele_head_s  = trel_sum_type'(tele_head_ff);
   assign tele_count_s = trel_sum_type'(tele_count_ff);
   assign warn_head_s  = trel_sum_type'(warn_head_ff);
   assign warn_count_s = trel_sum_type'(warn_count_ff);
   assign err_head_s   = trel_sum_type'(err_head_ff);
   assign err_count_s  = trel_sum_type'(err_count_ff);
   assign idx_s        = trel_sum_type'(idx_ff);

   assign warn_count_next = ring_next_count(warn_count_s, WARN_D);

   // read slots of the idx-th oldest entry, one per ring
   assign tele_rd_addr = TELE_AW'(ring_slot(tele_head_s, tele_count_s, idx_s, TELE_D));
   assign warn_rd_addr = WARN_AW'(ring_slot(warn_head_s, warn_count_s, idx_s, WARN_D));
   assign err_rd_addr  = ERR_AW'(ring_slot(err_head_s, err_count_s, idx_s, ERR_D));

   // ring writes happen in the execute step
   assign tele_we = cmd.execute && (func_ff == FUNC_LOG_TELE);
   assign warn_we = cmd.execute && (func_ff == FUNC_LOG_WARN);
   assign err_we  = cmd.execute && (func_ff == FUNC_LOG_ERR);

   // error procedure trigger: any error, or a warning that leaves its ring full
   assign error_event = err_we || (warn_we && (warn_count_next == WARN_D));

   trel_ram #(.WIDTH(ENTRY_W), .DEPTH(TELE_DEPTH)) u_tele_ram (
      .clock   (clock),
      .wr_en   (tele_we),
      .wr_addr (tele_head_ff),
      .wr_data (entry_ff),
      .rd_en   (cmd.execute),
      .rd_addr (tele_rd_addr),
      .rd_data (tele_rd_data)
   );

   trel_ram #(.WIDTH(ENTRY_W), .DEPTH(WARN_DEPTH)) u_warn_ram (
      .clock   (clock),
      .wr_en   (warn_we),
      .wr_addr (warn_head_ff),
      .wr_data (entry_ff),
      .rd_en   (cmd.execute),
      .rd_addr (warn_rd_addr),
      .rd_data (warn_rd_data)
   );

   trel_ram #(.WIDTH(ENTRY_W), .DEPTH(ERR_DEPTH)) u_err_ram (
      .clock   (clock),
      .wr_en   (err_we),
      .wr_addr (err_head_ff),
      .wr_data (entry_ff),
      .rd_en   (cmd.execute),
      .rd_addr (err_rd_addr),
      .rd_data (err_rd_data)
   );

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         cat_ff   <= req_category;
         idx_ff   <= req_entry_index;
         entry_ff <= {req_stamp, req_message_code, req_event_value};
      end
   end

   // ring heads, counts, sticky flag and first error record
   always_comb begin
      tele_head_in  = tele_head_ff;
      tele_count_in = tele_count_ff;
      warn_head_in  = warn_head_ff;
      warn_count_in = warn_count_ff;
      err_head_in   = err_head_ff;
      err_count_in  = err_count_ff;
      sticky_in     = sticky_ff;
      first_rec_in  = first_rec_ff;
      call_in       = call_ff;
      if (cmd.execute) begin
         call_in = 1'b0;
         if (tele_we) begin
            tele_head_in  = TELE_AW'(ring_next_head(tele_head_s, TELE_D));
            tele_count_in = TELE_CW'(ring_next_count(tele_count_s, TELE_D));
         end
         if (warn_we) begin
            warn_head_in  = WARN_AW'(ring_next_head(warn_head_s, WARN_D));
            warn_count_in = WARN_CW'(warn_count_next);
         end
         if (err_we) begin
            err_head_in  = ERR_AW'(ring_next_head(err_head_s, ERR_D));
            err_count_in = ERR_CW'(ring_next_count(err_count_s, ERR_D));
         end
         if (error_event) begin
            if (!sticky_ff) begin
               first_rec_in = entry_ff;
            end
            sticky_in = 1'b1;
            call_in   = handler_enable_ff;
         end
         if (func_ff == FUNC_CLEAR) begin
            tele_head_in  = '0;
            tele_count_in = '0;
            warn_head_in  = '0;
            warn_count_in = '0;
            err_head_in   = '0;
            err_count_in  = '0;
            sticky_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tele_head_ff      <= '0;
         tele_count_ff     <= '0;
         warn_head_ff      <= '0;
         warn_count_ff     <= '0;
         err_head_ff       <= '0;
         err_count_ff      <= '0;
         sticky_ff         <= 1'b0;
         first_rec_ff      <= '0;
         call_ff           <= 1'b0;
         handler_enable_ff <= 1'b0;
      end else begin
         tele_head_ff  <= tele_head_in;
         tele_count_ff <= tele_count_in;
         warn_head_ff  <= warn_head_in;
         warn_count_ff <= warn_count_in;
         err_head_ff   <= err_head_in;
         err_count_ff  <= err_count_in;
         sticky_ff     <= sticky_in;
         first_rec_ff  <= first_rec_in;
         call_ff       <= call_in;
         if (cfg_write) begin
            handler_enable_ff <= cfg_handler_enable;
         end
      end
   end

   // result of the step, from post-step counts and the RAM read data
   always_comb begin
      rsp_entry_in = '0;
      rsp_hit_in   = 1'b0;
      rsp_fill_in  = '0;
      case (func_ff)
         FUNC_LOG_TELE: begin
            rsp_fill_in = FILL_W'(tele_count_s);
         end
         FUNC_LOG_WARN: begin
            rsp_fill_in = FILL_W'(warn_count_s);
         end
         FUNC_LOG_ERR: begin
            rsp_fill_in = FILL_W'(err_count_s);
         end
         FUNC_READ: begin
            case (cat_ff)
               CAT_TELE: begin
                  rsp_fill_in = FILL_W'(tele_count_s);
                  rsp_hit_in  = (idx_s < tele_count_s);
                  if (rsp_hit_in) begin
                     rsp_entry_in = tele_rd_data;
                  end
               end
               CAT_WARN: begin
                  rsp_fill_in = FILL_W'(warn_count_s);
                  rsp_hit_in  = (idx_s < warn_count_s);
                  if (rsp_hit_in) begin
                     rsp_entry_in = warn_rd_data;
                  end
               end
               CAT_ERR: begin
                  rsp_fill_in = FILL_W'(err_count_s);
                  rsp_hit_in  = (idx_s < err_count_s);
                  if (rsp_hit_in) begin
                     rsp_entry_in = err_rd_data;
                  end
               end
               default: begin
                  rsp_fill_in = '0;
               end
            endcase
         end
         FUNC_READ_FIRST: begin
            rsp_entry_in = first_rec_ff;
            rsp_hit_in   = sticky_ff;
            rsp_fill_in  = FILL_W'(err_count_s);
         end
         default: begin
            rsp_fill_in = '0;
         end
      endcase
   end

   // response register: holds while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_entry_ff <= rsp_entry_in;
         rsp_hit_ff   <= rsp_hit_in;
         rsp_fill_ff  <= rsp_fill_in;
         rsp_flag_ff  <= sticky_ff;
         rsp_call_ff  <= call_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_stamp    = rsp_entry_ff[ENTRY_W-1 -: STAMP_W];
   assign rsp_out_code     = rsp_entry_ff[VALUE_W +: CODE_W];
   assign rsp_out_value    = rsp_entry_ff[VALUE_W-1:0];
   assign rsp_entry_valid  = rsp_hit_ff;
   assign rsp_fill_count   = rsp_fill_ff;
   assign rsp_error_flag   = rsp_flag_ff;
   assign rsp_handler_call = rsp_call_ff;

endmodule

/* rtl/core/triple_ring_event_logger.sv */
// Each request passes through the transfer itself, an execute step that
// writes the ring slot, updates heads, counts and the sticky error flag
// and issues the ring RAM read, and a response step in which the
// registered RAM read data forms the result. A result that is stalled
// stays in the output register; the next request is still taken meanwhile
// and waits in its response step only while that register is occupied.
// The handler enable register is written through the csr channel, which
// is always ready.
// ----------------------------------------------------------------------------
// triple_ring_event_logger
// Event logger with overwriting telemetry, warning and error rings, a sticky
// error flag with first error capture, and an optional handler pulse.
// ----------------------------------------------------------------------------
module triple_ring_event_logger (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_handler_enable,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [trel_pkg::FUNC_W-1:0]   req_func,
   input  logic [trel_pkg::CAT_W-1:0]    req_category,
   input  logic [trel_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [trel_pkg::STAMP_W-1:0]  req_stamp,
   input  logic [trel_pkg::CODE_W-1:0]   req_message_code,
   input  logic [trel_pkg::VALUE_W-1:0]  req_event_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [trel_pkg::STAMP_W-1:0]  rsp_out_stamp,
   output logic [trel_pkg::CODE_W-1:0]   rsp_out_code,
   output logic [trel_pkg::VALUE_W-1:0]  rsp_out_value,
   output logic                          rsp_entry_valid,
   output logic [trel_pkg::FILL_W-1:0]   rsp_fill_count,
   output logic                          rsp_error_flag,
   output logic                          rsp_handler_call
);

   import trel_pkg::*;

   trel_cmd_type    cmd;
   trel_status_type status;

   // configuration transfers are taken at any time
   assign csr_ready = 1'b1;

   trel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   trel_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg_write          (csr_valid),
      .cfg_handler_enable (csr_handler_enable),
      .req_func           (req_func),
      .req_category       (req_category),
      .req_entry_index    (req_entry_index),
      .req_stamp          (req_stamp),
      .req_message_code   (req_message_code),
      .req_event_value    (req_event_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_stamp      (rsp_out_stamp),
      .rsp_out_code       (rsp_out_code),
      .rsp_out_value      (rsp_out_value),
      .rsp_entry_valid    (rsp_entry_valid),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_error_flag     (rsp_error_flag),
      .rsp_handler_call   (rsp_handler_call)
   );

endmodule

/* rtl/core/trel_checker.sv */
// ----------------------------------------------------------------------------
// trel_checker
// Port level checks for the triple ring event logger, bound to the top level.
// ----------------------------------------------------------------------------
module trel_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [trel_pkg::STAMP_W-1:0]  rsp_out_stamp,
   input logic [trel_pkg::CODE_W-1:0]   rsp_out_code,
   input logic [trel_pkg::VALUE_W-1:0]  rsp_out_value,
   input logic                          rsp_entry_valid,
   input logic [trel_pkg::FILL_W-1:0]   rsp_fill_count,
   input logic                          rsp_error_flag,
   input logic                          rsp_handler_call
);

   import trel_pkg::*;

   // deepest ring bounds every fill count
   localparam int MAX_DEPTH = (TELE_DEPTH > WARN_DEPTH)
      ? ((TELE_DEPTH > ERR_DEPTH) ? TELE_DEPTH : ERR_DEPTH)
      : ((WARN_DEPTH > ERR_DEPTH) ? WARN_DEPTH : ERR_DEPTH);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_stamp)
         && $stable(rsp_out_code) && $stable(rsp_out_value)
         && $stable(rsp_fill_count) && $stable(rsp_entry_valid)
         && $stable(rsp_error_flag) && $stable(rsp_handler_call))
      else $error("stalled response changed");

   // a fill count never exceeds the deepest ring
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_fill_count) <= MAX_DEPTH)
      else $error("fill count beyond ring depth");

   // the handler is only called when the error flag is set
   a_call_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_handler_call |-> rsp_error_flag)
      else $error("handler call without error flag");

   // one request at a time: busy in the cycle after a transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while the previous one is in work");

endmodule

bind triple_ring_event_logger trel_checker u_trel_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triple ring event logger. A queue of requests
// feeds a clocked driver; a clocked monitor predicts every accepted transfer
// and checks each response field by field, in order. Both sides idle at
// random, and the response side holds off once long enough to back up the
// block. Runs pass through both handler enable settings.
// ----------------------------------------------------------------------------
module tb_top;
   import trel_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int PHASE_ITEMS    = 425;
   localparam int HOLD_CYCLES    = 80;

   // function codes the block ignores, and the category with no ring
   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
   localparam logic [CAT_W-1:0]  CAT_NONE     = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [CAT_W-1:0]   category;
      logic [IDX_W-1:0]   index;
      logic [STAMP_W-1:0] stamp;
      logic [CODE_W-1:0]  code;
      logic [VALUE_W-1:0] value;
   } log_request_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [CODE_W-1:0]  code;
      logic [VALUE_W-1:0] value;
   } log_entry_type;

   typedef struct packed {
      log_entry_type     data;
      logic              entry_valid;
      logic [FILL_W-1:0] fill;
      logic              error_flag;
      logic              handler_call;
   } log_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_handler_enable = 1'b0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [CAT_W-1:0]    req_category = '0;
   logic [IDX_W-1:0]    req_entry_index = '0;
   logic [STAMP_W-1:0]  req_stamp = '0;
   logic [CODE_W-1:0]   req_message_code = '0;
   logic [VALUE_W-1:0]  req_event_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STAMP_W-1:0]  rsp_out_stamp;
   logic [CODE_W-1:0]   rsp_out_code;
   logic [VALUE_W-1:0]  rsp_out_value;
   logic                rsp_entry_valid;
   logic [FILL_W-1:0]   rsp_fill_count;
   logic                rsp_error_flag;
   logic                rsp_handler_call;

   triple_ring_event_logger DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_handler_enable (csr_handler_enable),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_category       (req_category),
      .req_entry_index    (req_entry_index),
      .req_stamp          (req_stamp),
      .req_message_code   (req_message_code),
      .req_event_value    (req_event_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_stamp      (rsp_out_stamp),
      .rsp_out_code       (rsp_out_code),
      .rsp_out_value      (rsp_out_value),
      .rsp_entry_valid    (rsp_entry_valid),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_error_flag     (rsp_error_flag),
      .rsp_handler_call   (rsp_handler_call)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // stimulus and expected response stores
   log_request_type request_queue [$];
   log_result_type  expected_results [$];

   // logger image kept by the predictor
   log_entry_type ring_mem [3][TELE_DEPTH];
   int            ring_head [3];
   int            ring_count [3];
   int            ring_depth [3] = '{TELE_DEPTH, WARN_DEPTH, ERR_DEPTH};
   logic          sticky_error = 1'b0;
   log_entry_type first_error = '0;
   logic          handler_en_model = 1'b0;

   // progress and tallies
   int offered_count = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int log_count = 0;
   int read_count = 0;
   int clear_count = 0;
   int handler_pulses = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit progress;

   // next logger state and response for one accepted request
   function automatic log_result_type apply_request(log_request_type rq);
      log_result_type res;
      log_entry_type  ev;
      int             ring;
      int             slot;
      res = '0;
      ev.stamp = rq.stamp;
      ev.code  = rq.code;
      ev.value = rq.value;
      case (rq.func)
         FUNC_LOG_TELE, FUNC_LOG_WARN, FUNC_LOG_ERR: begin
            // log codes line up with the ring categories
            ring = int'(rq.func);
            ring_mem[ring][ring_head[ring]] = ev;
            ring_head[ring] = (ring_head[ring] + 1) % ring_depth[ring];
            if (ring_count[ring] < ring_depth[ring]) ring_count[ring]++;
            res.fill = FILL_W'(ring_count[ring]);
            // error entry, or a warning that leaves its ring full
            if (rq.func == FUNC_LOG_ERR ||
                (rq.func == FUNC_LOG_WARN && ring_count[ring] == ring_depth[ring])) begin
               if (!sticky_error) first_error = ev;
               sticky_error = 1'b1;
               res.handler_call = handler_en_model;
            end
         end
         FUNC_READ: begin
            if (rq.category != CAT_NONE) begin
               ring = int'(rq.category);
               res.fill = FILL_W'(ring_count[ring]);
               if (int'(rq.index) < ring_count[ring]) begin
                  slot = (ring_head[ring] + ring_depth[ring] - ring_count[ring]
                          + int'(rq.index)) % ring_depth[ring];
                  res.data = ring_mem[ring][slot];
                  res.entry_valid = 1'b1;
               end
            end
         end
         FUNC_READ_FIRST: begin
            res.data = first_error;
            res.entry_valid = sticky_error;
            res.fill = FILL_W'(ring_count[CAT_ERR]);
         end
         FUNC_CLEAR: begin
            for (int r = 0; r < 3; r++) begin
               ring_head[r] = 0;
               ring_count[r] = 0;
            end
            sticky_error = 1'b0;
         end
         default: begin
         end
      endcase
      res.error_flag = sticky_error;
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   function automatic log_request_type make_request(logic [FUNC_W-1:0] func,
                                                    logic [CAT_W-1:0] category,
                                                    logic [IDX_W-1:0] index,
                                                    logic [STAMP_W-1:0] stamp,
                                                    logic [CODE_W-1:0] code,
                                                    logic [VALUE_W-1:0] value);
      log_request_type rq;
      rq.func = func;
      rq.category = category;
      rq.index = index;
      rq.stamp = stamp;
      rq.code = code;
      rq.value = value;
      return rq;
   endfunction

   // one request with a weighted function and random content
   function automatic log_request_type random_request();
      log_request_type rq;
      int              pick;
      rq.category = CAT_W'($urandom_range(3));
      rq.index    = IDX_W'($urandom_range(15));
      rq.stamp    = $urandom;
      rq.code     = CODE_W'($urandom);
      rq.value    = $urandom;
      pick = $urandom_range(99);
      if (pick < 28) rq.func = FUNC_LOG_TELE;
      else if (pick < 42) rq.func = FUNC_LOG_WARN;
      else if (pick < 50) rq.func = FUNC_LOG_ERR;
      else if (pick < 82 || pick > 95) rq.func = FUNC_READ;
      else if (pick < 90) rq.func = FUNC_READ_FIRST;
      else if (pick < 93) rq.func = FUNC_CLEAR;
      else rq.func = ($urandom_range(1) == 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      // reads mostly address a real ring
      if (rq.func == FUNC_READ)
         rq.category = ($urandom_range(15) == 0) ? CAT_NONE : CAT_W'($urandom_range(2));
      return rq;
   endfunction

   // random traffic mixed with bursts that fill rings and sweep them
   task automatic queue_random_items(int target);
      log_request_type  rq;
      int               added;
      int               pick;
      int               n;
      logic [CAT_W-1:0] cat;
      added = 0;
      while (added < target) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            // warning storm that fills the warning ring
            n = $urandom_range(12, 8);
            repeat (n) begin
               rq = random_request();
               rq.func = FUNC_LOG_WARN;
               request_queue.push_back(rq);
            end
            added += n;
         end else if (pick < 10) begin
            n = $urandom_range(20, 14);
            repeat (n) begin
               rq = random_request();
               rq.func = FUNC_LOG_TELE;
               request_queue.push_back(rq);
            end
            added += n;
         end else if (pick < 14) begin
            // sweep every index of one ring
            cat = CAT_W'($urandom_range(2));
            for (int i = 0; i < 16; i++) begin
               rq = random_request();
               rq.func = FUNC_READ;
               rq.category = cat;
               rq.index = IDX_W'(i);
               request_queue.push_back(rq);
            end
            added += 16;
         end else begin
            rq = random_request();
            request_queue.push_back(rq);
            if (rq.func <= FUNC_CLEAR) added++;
         end
      end
   endtask

   task automatic write_handler_enable(logic en);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_handler_enable <= en;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      handler_en_model = en;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (request_queue.size() != 0 || expected_results.size() != 0) @(posedge clock);
   endtask

   // request driver: holds a stalled transfer, else offers the next request or idles at random
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && accepted_count != offered_count)) begin
         if (request_queue.size() != 0 &&
             !($urandom_range(99) < 7 && !(accepted_count >= 700 && accepted_count < 1000))) begin
            req_func         <= request_queue[0].func;
            req_category     <= request_queue[0].category;
            req_entry_index  <= request_queue[0].index;
            req_stamp        <= request_queue[0].stamp;
            req_message_code <= request_queue[0].code;
            req_event_value  <= request_queue[0].value;
            req_valid        <= 1'b1;
            offered_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: random, one quiet window, and one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && checked_count >= 300) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < 7) && !(checked_count >= 1100 && checked_count < 1400);
      end
   end

   // monitor: check responses, predict accepted requests, watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         progress = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            checked_count++;
            if (expected_results.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_count++;
            end else begin
               log_result_type want;
               want = expected_results.pop_front();
               check_field("out_stamp", want.data.stamp, rsp_out_stamp);
               check_field("out_code", want.data.code, rsp_out_code);
               check_field("out_value", want.data.value, rsp_out_value);
               check_field("entry_valid", want.entry_valid, rsp_entry_valid);
               check_field("fill_count", want.fill, rsp_fill_count);
               check_field("error_flag", want.error_flag, rsp_error_flag);
               check_field("handler_call", want.handler_call, rsp_handler_call);
            end
         end
         if (req_valid && !req_stall) begin
            log_result_type res;
            progress = 1'b1;
            res = apply_request(make_request(req_func, req_category, req_entry_index,
                                             req_stamp, req_message_code, req_event_value));
            expected_results.push_back(res);
            if (req_func <= FUNC_LOG_ERR) log_count++;
            else if (req_func <= FUNC_READ_FIRST) read_count++;
            else if (req_func == FUNC_CLEAR) clear_count++;
            if (res.handler_call) handler_pulses++;
            void'(request_queue.pop_front());
            accepted_count++;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // handler off: empty reads, extremes, bad category, spare codes, one error
      write_handler_enable(1'b0);
      request_queue.push_back(make_request(FUNC_READ_FIRST, CAT_TELE, 4'd0, '0, '0, '0));
      request_queue.push_back(make_request(FUNC_READ, CAT_TELE, 4'd0, '0, '0, '0));
      request_queue.push_back(make_request(FUNC_LOG_TELE, CAT_NONE, 4'hF,
                                           32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      request_queue.push_back(make_request(FUNC_LOG_TELE, CAT_TELE, 4'd0, '0, '0, '0));
      request_queue.push_back(make_request(FUNC_READ, CAT_TELE, 4'd0, '0, '0, '0));
      request_queue.push_back(make_request(FUNC_READ, CAT_TELE, 4'd1, '0, '0, '0));
      request_queue.push_back(make_request(FUNC_READ, CAT_TELE, 4'd15, '0, '0, '0));
      request_queue.push_back(make_request(FUNC_READ, CAT_NONE, 4'd0, '0, '0, '0));
      request_queue.push_back(make_request(FUNC_SPARE_6, CAT_NONE, 4'hF,
                                           32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      request_queue.push_back(make_request(FUNC_SPARE_7, CAT_ERR, 4'd5,
                                           32'h1234_5678, 16'hBEEF, 32'h9ABC_DEF0));
      request_queue.push_back(make_request(FUNC_LOG_ERR, CAT_ERR, 4'd0,
                                           32'h8000_0001, 16'h8001, 32'h7FFF_FFFE));
      request_queue.push_back(make_request(FUNC_READ_FIRST, CAT_ERR, 4'd0, '0, '0, '0));
      request_queue.push_back(make_request(FUNC_CLEAR, CAT_TELE, 4'd0, '0, '0, '0));
      wait_idle();

      // handler on: warning ring fills, overwrites, then an error
      write_handler_enable(1'b1);
      for (int i = 0; i < WARN_DEPTH + 1; i++)
         request_queue.push_back(make_request(FUNC_LOG_WARN, CAT_WARN, 4'd0,
                                              32'h100 + i, 16'h200 + i, 32'h300 + i));
      request_queue.push_back(make_request(FUNC_READ, CAT_WARN, 4'd7, '0, '0, '0));
      request_queue.push_back(make_request(FUNC_READ_FIRST, CAT_WARN, 4'd0, '0, '0, '0));
      request_queue.push_back(make_request(FUNC_LOG_ERR, CAT_ERR, 4'd0,
                                           32'hDEAD_0000, 16'h0ACE, 32'h0000_BEEF));
      wait_idle();

      // random phases alternate the handler setting
      for (int phase = 0; phase < 4; phase++) begin
         write_handler_enable(phase % 2 == 1);
         queue_random_items(PHASE_ITEMS);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d responses never arrived", expected_results.size());
         mismatch_count++;
      end

      $display("ran %0d requests: %0d logs, %0d reads, %0d clears; %0d responses checked",
               accepted_count, log_count, read_count, clear_count, checked_count);
      $display("handler pulses predicted %0d, mismatches %0d", handler_pulses, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/trel_pkg.sv
rtl/core/trel_ram.sv
rtl/core/trel_ctrl.sv
rtl/core/trel_dp.sv
rtl/core/triple_ring_event_logger.sv
rtl/core/trel_checker.sv
tb/tb_top.sv
